/* src/rank_enumeration_sort_macros.svh */
// Assertion macros for the rank enumeration sort block.
// Used by the top level; expects aclk and aresetn in the including scope.
`ifndef RANK_ENUMERATION_SORT_MACROS_SVH
`define RANK_ENUMERATION_SORT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define RES_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RES_ASSERT_SAME(lbl, ante, cons, msg)
`define RES_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* src/res_pkg.sv */
// Shared types and constants for the rank enumeration sort block.
// No dependencies; used by res_ctrl, res_datapath and rank_enumeration_sort.
package res_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int GRP_SIZE  = 8;
    localparam int GRP_N     = (MAX_ITEMS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W     = $clog2(GRP_SIZE + 1);
    localparam int PAD_W     = GRP_N * GRP_SIZE;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
        logic                     overflow;
    } out_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_SCATTER,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic load;
        logic scatter;
        logic drain;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scatter_last;
        logic drain_done;
    } sts_t;

endpackage

/* src/res_ctrl.sv */
// Sequencer for the rank enumeration sort: load, settle, scatter, drain.
// Depends on res_pkg for the state, command and status types.
module res_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            in_last,
    input  res_pkg::sts_t   sts,
    output logic            s_ready,
    output res_pkg::cmd_t   cmd,
    output res_pkg::state_t state
);

    res_pkg::state_t state_reg;
    res_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= res_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            res_pkg::ST_LOAD: begin
                if (s_valid && in_last) begin
                    state_next = res_pkg::ST_SETTLE;
                end
            end
            // settle state: wait for the last rank to land
            res_pkg::ST_SETTLE: begin
                state_next = res_pkg::ST_SCATTER;
            end
            res_pkg::ST_SCATTER: begin
                if (sts.scatter_last) begin
                    state_next = res_pkg::ST_DRAIN;
                end
            end
            res_pkg::ST_DRAIN: begin
                if (sts.drain_done) begin
                    state_next = res_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = res_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            res_pkg::ST_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            res_pkg::ST_SETTLE: begin
                cmd = '0;
            end
            res_pkg::ST_SCATTER: begin
                cmd.scatter = 1'b1;
            end
            res_pkg::ST_DRAIN: begin
                cmd.drain  = 1'b1;
                cmd.finish = sts.drain_done;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

/* src/res_datapath.sv */
// Element cells with parallel comparators, rank pipeline, sort memory and output register.
// Depends on res_pkg for widths, payload and command/status types.
module res_datapath (
    input  logic          aclk,
    input  logic          aresetn,
    input  res_pkg::cmd_t cmd,
    input  res_pkg::in_t  in_data,
    input  logic          m_ready,
    output res_pkg::sts_t sts,
    output logic          m_valid,
    output res_pkg::out_t out_data
);

    localparam int MAX_ITEMS = res_pkg::MAX_ITEMS;
    localparam int DATA_W    = res_pkg::DATA_W;
    localparam int IDX_W     = res_pkg::IDX_W;
    localparam int CNT_W     = res_pkg::CNT_W;
    localparam int GRP_SIZE  = res_pkg::GRP_SIZE;
    localparam int GRP_N     = res_pkg::GRP_N;
    localparam int GRP_W     = res_pkg::GRP_W;
    localparam int PAD_W     = res_pkg::PAD_W;

    // cell row
    logic signed [DATA_W-1:0] store_reg [MAX_ITEMS];
    logic signed [DATA_W-1:0] store_next[MAX_ITEMS];
    logic [IDX_W-1:0]         rank_reg  [MAX_ITEMS];
    logic [IDX_W-1:0]         rank_next [MAX_ITEMS];

    logic [CNT_W-1:0] count_reg;
    logic             dropped_reg;
    logic [IDX_W-1:0] scat_cnt_reg;
    logic [CNT_W-1:0] rd_ptr_reg;

    // rank pipeline: group counts of the new item, registered and written to its rank in the next cycle
    logic [GRP_W-1:0] part_reg [GRP_N];
    logic [GRP_W-1:0] part_next[GRP_N];
    logic             pend_valid_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic [CNT_W-1:0] pend_sum;

    logic [MAX_ITEMS-1:0] valid;
    logic [MAX_ITEMS-1:0] le;
    logic [MAX_ITEMS-1:0] inc;
    logic [PAD_W-1:0]     le_pad;
    logic                 full;
    logic                 do_load;
    logic                 rd_en;

    // sort memory, addressed by rank
    logic signed [DATA_W-1:0] sort_mem [MAX_ITEMS];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     final_reg;
    logic                     out_valid_reg;

    always_comb begin
        full    = (count_reg == CNT_W'(MAX_ITEMS));
        do_load = cmd.load && !full;
        for (int i = 0; i < MAX_ITEMS; i++) begin
            valid[i] = (CNT_W'(i) < count_reg);
            le[i]    = valid[i] && (store_reg[i] <= in_data.value);
            inc[i]   = do_load && valid[i] && !le[i];
        end
    end

    always_comb begin
        le_pad = PAD_W'(le);
        for (int g = 0; g < GRP_N; g++) begin
            part_next[g] = '0;
            for (int b = 0; b < GRP_SIZE; b++) begin
                part_next[g] = part_next[g] + GRP_W'(le_pad[g*GRP_SIZE + b]);
            end
        end
    end

    always_comb begin
        pend_sum = '0;
        for (int g = 0; g < GRP_N; g++) begin
            pend_sum = pend_sum + CNT_W'(part_reg[g]);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            rank_next[i] = (pend_valid_reg && pend_idx_reg == IDX_W'(i))
                           ? pend_sum[IDX_W-1:0] : rank_reg[i];
            rank_next[i] = rank_next[i] + IDX_W'(inc[i]);
            store_next[i] = store_reg[i];
            if (do_load && count_reg[IDX_W-1:0] == IDX_W'(i)) begin
                store_next[i] = in_data.value;
            end
        end
        // advance the row toward cell 0, which feeds the sort memory
        if (cmd.scatter) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                store_next[i] = store_reg[i+1];
                rank_next[i]  = rank_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            store_reg[i] <= store_next[i];
            rank_reg[i]  <= rank_next[i];
        end
        for (int g = 0; g < GRP_N; g++) begin
            part_reg[g] <= part_next[g];
        end
        pend_idx_reg <= count_reg[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            scat_cnt_reg   <= '0;
            rd_ptr_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= do_load;
            if (cmd.finish) begin
                count_reg    <= '0;
                dropped_reg  <= 1'b0;
                scat_cnt_reg <= '0;
                rd_ptr_reg   <= '0;
            end else begin
                if (do_load) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                // drop items past capacity
                if (cmd.load && full) begin
                    dropped_reg <= 1'b1;
                end
                if (cmd.scatter) begin
                    scat_cnt_reg <= scat_cnt_reg + IDX_W'(1);
                end
                if (rd_en) begin
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                end
            end
            if (rd_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rd_en = cmd.drain && (rd_ptr_reg != count_reg) && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (cmd.scatter) begin
            sort_mem[rank_reg[0]] <= store_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= sort_mem[rd_ptr_reg[IDX_W-1:0]];
            final_reg   <= (rd_ptr_reg == count_reg - CNT_W'(1));
        end
    end

    assign sts.scatter_last = (CNT_W'(scat_cnt_reg) == count_reg - CNT_W'(1));
    assign sts.drain_done   = (rd_ptr_reg == count_reg) && (!out_valid_reg || m_ready);

    assign m_valid               = out_valid_reg;
    assign out_data.sorted_value = rd_data_reg;
    assign out_data.final_res    = final_reg;
    assign out_data.overflow     = dropped_reg;

endmodule

/* src/rank_enumeration_sort.sv */
// Stable rank sort of up to 64 signed values; load takes 1 item per cycle.
// After the last item: a settle state, then scatter (one cell into the sort memory
// per cycle), then one result per loaded item at 1 per cycle while m_ready is high.
// No new request is taken until the run's final result has been delivered.
// aresetn (synchronous, active low) clears the sequencer, counts and flags;
// the element cells and sort memory keep their contents and need no clearing.
module rank_enumeration_sort (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  res_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output res_pkg::out_t m_payload
);

`include "rank_enumeration_sort_macros.svh"

    res_pkg::cmd_t   cmd;
    res_pkg::sts_t   sts;
    res_pkg::state_t state;

    logic final_fire;
    logic st_settle;
    logic st_scatter;
    logic st_drain;

    res_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_last (s_payload.last),
        .sts     (sts),
        .s_ready (s_ready),
        .cmd     (cmd),
        .state   (state)
    );

    res_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_payload),
        .m_ready  (m_ready),
        .sts      (sts),
        .m_valid  (m_valid),
        .out_data (m_payload)
    );

    assign final_fire = m_valid && m_ready && m_payload.final_res;
    assign st_settle  = (state == res_pkg::ST_SETTLE);
    assign st_scatter = (state == res_pkg::ST_SCATTER);
    assign st_drain   = (state == res_pkg::ST_DRAIN);

    `RES_ASSERT_SAME(a_no_load_while_out, s_ready, !m_valid, "request taken while result pending")
    `RES_ASSERT_SAME(a_out_only_drain, m_valid, st_drain, "result outside drain")
    `RES_ASSERT_NEXT(a_final_ends_run, final_fire, !m_valid, "result after final")
    `RES_ASSERT_NEXT(a_settle_to_scatter, st_settle, st_scatter, "settle did not advance")

endmodule
